/* hw/rtl/tick_countdown_task_dispatcher_unit_macros.svh */
// Assertion helpers; the using module provides clk and rst_n.
`ifndef TICK_COUNTDOWN_TASK_DISPATCHER_UNIT_MACROS_SVH
`define TICK_COUNTDOWN_TASK_DISPATCHER_UNIT_MACROS_SVH

// Same-cycle implication.
`define TCDU_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcdu: same-cycle check failed");

// Next-cycle implication.
`define TCDU_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcdu: next-cycle check failed");

`endif

/* hw/rtl/tcdu_pkg.sv */
package tcdu_pkg;

  typedef enum logic [2:0] {
    FN_TICK     = 3'd0,
    FN_ADD      = 3'd1,
    FN_RELOAD   = 3'd2,
    FN_DISPATCH = 3'd3,
    FN_SET      = 3'd4,
    FN_TESTCLR  = 3'd5,
    FN_CLEAR    = 3'd6,
    FN_STATUS   = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_DSCAN,
    ST_DRD,
    ST_DNONE,
    ST_SRD,
    ST_SOP
  } state_t;

  localparam int MAX_SERVE = 8;

  typedef struct packed {
    logic [15:0] countdown;
    logic [31:0] runs;
  } entry_t;

  typedef struct packed {
    logic [2:0]  served_slot;
    logic        served_valid;
    logic        last;
    logic        flag_was_set;
    logic [31:0] runs;
    logic [15:0] remaining_ms;
    logic        is_ready;
  } res_t;

endpackage

/* hw/rtl/tick_countdown_task_dispatcher_unit.sv */
// Channel | ports  | tdata (low bit up)                           | tuser        | tlast
// --------+--------+----------------------------------------------+--------------+------
// input   | in_*   | slot[2:0] reload_ms[18:3]                    | func[2:0]    | -
// output  | out_*  | served_slot[2:0] flag_was_set[3] runs[35:4]  | served_valid | last
//         |        | remaining_ms[51:36] is_ready[52]             |              |
// One item at a time; the input is taken again only once the engine is back in idle.
// Slot ops read, modify-write, then return. A tick first sweeps the slot RAM, one
// slot RMW a cycle, then does the slot op.
// Dispatch scans the slots in order and serves each ready slot up to the last one served;
// with nothing ready it only returns.
// Reset clears the valid bits of the slot RAM at once; no clearing pass.
// A stalled output holds the engine; the input is not taken until the item is done.
module tick_countdown_task_dispatcher_unit #(
  parameter int TASKS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // slot, reload_ms
  input  logic [2:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // served_slot, flag_was_set, runs, remaining_ms, is_ready
  output logic        out_tuser,  // served_valid
  output logic        out_tlast
);

`include "tick_countdown_task_dispatcher_unit_macros.svh"

  localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int CW = $clog2(TASKS + 1);
  localparam int SW = (CW > 3) ? CW : 3;

  tcdu_pkg::state_t st_r, st_nxt;
  tcdu_pkg::func_t  func_r, func_nxt;
  logic [2:0]       slot_r, slot_nxt;
  logic [15:0]      reload_r, reload_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [3:0]       n_r, n_nxt;
  logic             p_vld_r, p_vld_nxt;
  logic [IW-1:0]    rd_idx_r;
  logic [TASKS-1:0] rdy_r, rdy_nxt;
  logic [TASKS-1:0] flg_r, flg_nxt;
  logic [TASKS-1:0] cdv_r, cdv_nxt;
  logic [TASKS-1:0] runv_r, runv_nxt;
  logic             out_vld_r, out_vld_nxt;
  tcdu_pkg::res_t   out_res_r;

  logic              rd_en, wr_en, out_ld, out_space, oor, more, last_c;
  logic [IW-1:0]     rd_addr, wr_addr, sidx, scan_idx;
  tcdu_pkg::entry_t  rd_data, wr_data;
  tcdu_pkg::res_t    ld_res;
  logic [15:0]       cd_use, cd_dec, cd_new;
  logic [31:0]       runs_use, runs_inc;
  logic [SW-1:0]     s_ext;
  logic              flg_new, rdy_new, flag_rep;
  logic [TASKS-1:0]  above;

  tcdu_slot_ram #(
    .DEPTH(TASKS),
    .AW   (IW)
  ) u_ram (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  assign in_tready  = (st_r == tcdu_pkg::ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_res_r.is_ready, out_res_r.remaining_ms, out_res_r.runs,
                       out_res_r.flag_was_set, out_res_r.served_slot};
  assign out_tuser  = out_res_r.served_valid;
  assign out_tlast  = out_res_r.last;

  assign out_space = !out_vld_r || out_tready;
  assign s_ext     = SW'(slot_r);
  assign oor       = (s_ext >= SW'(TASKS));
  assign sidx      = s_ext[IW-1:0];
  assign scan_idx  = cnt_r[IW-1:0];
  assign cd_use    = cdv_r[rd_idx_r] ? rd_data.countdown : 16'd0;
  assign runs_use  = runv_r[rd_idx_r] ? rd_data.runs : 32'd0;
  assign cd_dec    = cd_use - 16'd1;
  assign runs_inc  = runs_use + 32'd1;

  always_comb begin
    for (int j = 0; j < TASKS; j++) begin
      above[j] = (j > int'(rd_idx_r));
    end
  end
  assign more   = |(rdy_r & above);
  assign last_c = (n_r == 4'(tcdu_pkg::MAX_SERVE - 1)) || !more;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      tcdu_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (tcdu_pkg::func_t'(in_tuser) == tcdu_pkg::FN_TICK) begin
            st_nxt = tcdu_pkg::ST_TICK;
          end else if (tcdu_pkg::func_t'(in_tuser) == tcdu_pkg::FN_DISPATCH) begin
            st_nxt = (|rdy_r) ? tcdu_pkg::ST_DSCAN : tcdu_pkg::ST_DNONE;
          end else begin
            st_nxt = tcdu_pkg::ST_SRD;
          end
        end
      end
      tcdu_pkg::ST_TICK: begin
        if (cnt_r == CW'(TASKS) && !p_vld_r) begin
          st_nxt = tcdu_pkg::ST_SRD;
        end
      end
      tcdu_pkg::ST_DSCAN: begin
        if (rdy_r[scan_idx]) begin
          st_nxt = tcdu_pkg::ST_DRD;
        end
      end
      tcdu_pkg::ST_DRD: begin
        if (out_space) begin
          st_nxt = last_c ? tcdu_pkg::ST_IDLE : tcdu_pkg::ST_DSCAN;
        end
      end
      tcdu_pkg::ST_DNONE: begin
        if (out_space) begin
          st_nxt = tcdu_pkg::ST_IDLE;
        end
      end
      tcdu_pkg::ST_SRD: begin
        if (!oor) begin
          st_nxt = tcdu_pkg::ST_SOP;
        end else if (out_space) begin
          st_nxt = tcdu_pkg::ST_IDLE;
        end
      end
      tcdu_pkg::ST_SOP: begin
        if (out_space) begin
          st_nxt = tcdu_pkg::ST_IDLE;
        end
      end
      default: st_nxt = tcdu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    func_nxt    = func_r;
    slot_nxt    = slot_r;
    reload_nxt  = reload_r;
    cnt_nxt     = cnt_r;
    n_nxt       = n_r;
    p_vld_nxt   = 1'b0;
    rdy_nxt     = rdy_r;
    flg_nxt     = flg_r;
    cdv_nxt     = cdv_r;
    runv_nxt    = runv_r;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = rd_idx_r;
    wr_data     = '0;
    out_ld      = 1'b0;
    ld_res      = '0;
    cd_new      = cd_use;
    rdy_new     = rdy_r[rd_idx_r];
    flg_new     = flg_r[rd_idx_r];
    flag_rep    = flg_r[rd_idx_r];
    unique case (st_r)
      tcdu_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          func_nxt   = tcdu_pkg::func_t'(in_tuser);
          slot_nxt   = in_tdata[2:0];
          reload_nxt = in_tdata[18:3];
          cnt_nxt    = '0;
          n_nxt      = '0;
          if (tcdu_pkg::func_t'(in_tuser) == tcdu_pkg::FN_CLEAR) begin
            runv_nxt = '0;
          end
        end
      end
      tcdu_pkg::ST_TICK: begin
        if (cnt_r != CW'(TASKS)) begin
          rd_en     = 1'b1;
          rd_addr   = scan_idx;
          cnt_nxt   = cnt_r + CW'(1);
          p_vld_nxt = 1'b1;
        end
        if (p_vld_r && cd_use != 16'd0) begin
          wr_en              = 1'b1;
          wr_data.countdown  = cd_dec;
          wr_data.runs       = runs_use;
          cdv_nxt[rd_idx_r]  = 1'b1;
          runv_nxt[rd_idx_r] = 1'b1;
          if (cd_dec == 16'd0) begin
            rdy_nxt[rd_idx_r] = 1'b1;
          end
        end
      end
      tcdu_pkg::ST_DSCAN: begin
        if (rdy_r[scan_idx]) begin
          rd_en   = 1'b1;
          rd_addr = scan_idx;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      tcdu_pkg::ST_DRD: begin
        if (out_space) begin
          wr_en               = 1'b1;
          wr_data.countdown   = cd_use;
          wr_data.runs        = runs_inc;
          cdv_nxt[rd_idx_r]   = 1'b1;
          runv_nxt[rd_idx_r]  = 1'b1;
          rdy_nxt[rd_idx_r]   = 1'b0;
          n_nxt               = n_r + 4'd1;
          cnt_nxt             = cnt_r + CW'(1);
          out_ld              = 1'b1;
          ld_res.served_slot  = 3'(rd_idx_r);
          ld_res.served_valid = 1'b1;
          ld_res.last         = last_c;
          ld_res.flag_was_set = flg_r[rd_idx_r];
          ld_res.runs         = runs_inc;
          ld_res.remaining_ms = cd_use;
          ld_res.is_ready     = 1'b0;
        end
      end
      tcdu_pkg::ST_DNONE: begin
        if (out_space) begin
          out_ld      = 1'b1;
          ld_res.last = 1'b1;
        end
      end
      tcdu_pkg::ST_SRD: begin
        if (!oor) begin
          rd_en   = 1'b1;
          rd_addr = sidx;
        end else if (out_space) begin
          out_ld             = 1'b1;
          ld_res.served_slot = slot_r;
          ld_res.last        = 1'b1;
        end
      end
      tcdu_pkg::ST_SOP: begin
        if (func_r inside {tcdu_pkg::FN_ADD, tcdu_pkg::FN_RELOAD}) begin
          cd_new = reload_r;
        end
        if (func_r == tcdu_pkg::FN_ADD) begin
          rdy_new = 1'b1;
        end
        if (func_r == tcdu_pkg::FN_SET) begin
          flg_new = 1'b1;
        end else if (func_r == tcdu_pkg::FN_TESTCLR) begin
          flg_new = 1'b0;
        end
        if (func_r != tcdu_pkg::FN_TESTCLR) begin
          flag_rep = flg_new;
        end
        if (out_space) begin
          wr_en               = 1'b1;
          wr_data.countdown   = cd_new;
          wr_data.runs        = runs_use;
          cdv_nxt[rd_idx_r]   = 1'b1;
          runv_nxt[rd_idx_r]  = 1'b1;
          rdy_nxt[rd_idx_r]   = rdy_new;
          flg_nxt[rd_idx_r]   = flg_new;
          out_ld              = 1'b1;
          ld_res.served_slot  = slot_r;
          ld_res.last         = 1'b1;
          ld_res.flag_was_set = flag_rep;
          ld_res.runs         = runs_use;
          ld_res.remaining_ms = cd_new;
          ld_res.is_ready     = rdy_new;
        end
      end
      default: begin
      end
    endcase
    out_vld_nxt = out_ld || (out_vld_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= tcdu_pkg::ST_IDLE;
      cnt_r     <= '0;
      n_r       <= '0;
      p_vld_r   <= 1'b0;
      rdy_r     <= '0;
      flg_r     <= '0;
      cdv_r     <= '0;
      runv_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      cnt_r     <= cnt_nxt;
      n_r       <= n_nxt;
      p_vld_r   <= p_vld_nxt;
      rdy_r     <= rdy_nxt;
      flg_r     <= flg_nxt;
      cdv_r     <= cdv_nxt;
      runv_r    <= runv_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    slot_r   <= slot_nxt;
    reload_r <= reload_nxt;
    if (rd_en) begin
      rd_idx_r <= rd_addr;
    end
    if (out_ld) begin
      out_res_r <= ld_res;
    end
  end

  `TCDU_ASSERT_IMP(a_no_rw_collide, wr_en && rd_en, wr_addr != rd_addr)
  `TCDU_ASSERT_IMP(a_load_has_room, out_ld, !out_vld_r || out_tready)
  `TCDU_ASSERT_IMP(a_serve_is_ready, st_r == tcdu_pkg::ST_DRD, rdy_r[rd_idx_r])
  `TCDU_ASSERT_IMP(a_tick_drained, st_r == tcdu_pkg::ST_TICK && st_nxt != tcdu_pkg::ST_TICK, !p_vld_r)
  `TCDU_ASSERT_NXT(a_accept_busy, in_tvalid && in_tready, st_r != tcdu_pkg::ST_IDLE)

endmodule

/* hw/rtl/tcdu_slot_ram.sv */
module tcdu_slot_ram #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output tcdu_pkg::entry_t     rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  tcdu_pkg::entry_t     wr_data
);

  tcdu_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
